// ----- src/wbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Word break segmenter package
// Word types for the request and response channels, the dictionary load
// bundle that is broadcast to the cells, and the request kind codes.
// ----------------------------------------------------------------------------
package wbs_pkg;

   localparam int KIND_W  = 2;
   localparam int SLOT_W  = 4;
   localparam int WORD_W  = 64;
   localparam int LEN_W   = 4;
   localparam int CHAR_W  = 8;

   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TEXT  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] word_slot;
      logic [WORD_W-1:0] word_bytes;
      logic [LEN_W-1:0]  word_length;
      logic [CHAR_W-1:0] text_char;
      logic              last_char;
   } req_type;

   typedef struct packed {
      logic prefix_breakable;
      logic is_end;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [WORD_W-1:0] bytes;
      logic [LEN_W-1:0]  length;
   } load_type;

endpackage

// ----- src/wbs_cell.sv -----
// ----------------------------------------------------------------------------
// Word break segmenter dictionary cell
// Holds one dictionary slot, matches it against the byte history and the
// split history, and passes the running hit flag on to the next cell.
// ----------------------------------------------------------------------------
module wbs_cell #(
   parameter int MAX_WORD_LEN = 8,
   parameter int SLOT_INDEX   = 0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  wbs_pkg::load_type                      load,
   input  logic [MAX_WORD_LEN-1:0][wbs_pkg::CHAR_W-1:0] byte_hist,
   input  logic [MAX_WORD_LEN-1:0]                split_hist,
   input  logic                                   hit_in,
   output logic                                   hit_out
);
   import wbs_pkg::*;

   localparam int HIW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;
   logic [LEN_W-1:0]  length_ff;
   logic [LEN_W-1:0]  length_in;
   logic              valid_ff;
   logic              valid_in;
   logic              hit_ff;
   logic              hit_in_next;
   logic              slot_sel;
   logic              len_ok;
   logic              bytes_eq;
   logic              match;
   logic [LEN_W-1:0]  pos;
   logic [LEN_W-1:0]  len_m1;

   assign slot_sel = load.en && (32'(load.slot) == 32'(SLOT_INDEX));
   assign len_ok   = (load.length != '0) && (32'(load.length) <= 32'(MAX_WORD_LEN));
   assign len_m1   = length_ff - LEN_W'(1);

   always_comb begin
      word_in   = word_ff;
      length_in = length_ff;
      valid_in  = valid_ff;
      if (slot_sel) begin
         if (len_ok) begin
            word_in   = load.bytes;
            length_in = load.length;
            valid_in  = 1'b1;
         end else begin
            length_in = '0;
            valid_in  = 1'b0;
         end
      end
   end

   always_comb begin
      bytes_eq = 1'b1;
      pos      = '0;
      for (int m = 0; m < MAX_WORD_LEN; m++) begin
         if (LEN_W'(m) < length_ff) begin
            pos = len_m1 - LEN_W'(m);
            if (byte_hist[pos[HIW-1:0]] != word_ff[8*m +: 8]) begin
               bytes_eq = 1'b0;
            end
         end
      end
   end

   assign match       = valid_ff && split_hist[len_m1[HIW-1:0]] && bytes_eq;
   assign hit_in_next = hit_in | match;

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (reset) begin
         length_ff <= '0;
         valid_ff  <= 1'b0;
         hit_ff    <= 1'b0;
      end else begin
         length_ff <= length_in;
         valid_ff  <= valid_in;
         hit_ff    <= hit_in_next;
      end
   end

   assign hit_out = hit_ff;

endmodule

// ----- src/word_break_segmenter_unit.sv -----
// ----------------------------------------------------------------------------
// Word break segmenter
// Streams text bytes and reports after each byte whether the text so far
// splits into dictionary words.
// ----------------------------------------------------------------------------
// The request channel carries one word per item: a dictionary load, a text
// byte or a begin. A load writes one slot cell and returns nothing. A begin
// clears the histories and returns a splittable empty prefix in the cycle
// after acceptance. A text byte shifts into the byte history, and the hit
// flag then ripples through the row of DICT_WORDS cells, one cell per cycle;
// its response is registered once the flag leaves the last cell and the
// output register is free. The next request can be taken in the cycle that
// response appears, not before; loads and begins leave the unit idle. The
// response sits in an output register: a load is accepted while it waits,
// and a begin or a finished byte waits until the receiver lowers rsp_stall.
// Reset clears the dictionary, both histories and the response valid flag;
// until a begin arrives every byte reports a prefix that does not split.
// ----------------------------------------------------------------------------
module word_break_segmenter_unit #(
   parameter int DICT_WORDS   = 16,
   parameter int MAX_WORD_LEN = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wbs_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wbs_pkg::rsp_type rsp
);
   import wbs_pkg::*;

   localparam int CNT_W = $clog2(DICT_WORDS + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type                              state_ff;
   state_type                              state_in;
   logic [CNT_W-1:0]                       cnt_ff;
   logic [CNT_W-1:0]                       cnt_in;
   logic [MAX_WORD_LEN-1:0][CHAR_W-1:0]    byte_hist_ff;
   logic [MAX_WORD_LEN-1:0][CHAR_W-1:0]    byte_hist_in;
   logic [MAX_WORD_LEN-1:0]                split_hist_ff;
   logic [MAX_WORD_LEN-1:0]                split_hist_in;
   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   rsp_type                                rsp_ff;
   rsp_type                                rsp_in;
   logic                                   last_ff;
   logic                                   last_in;
   logic                                   out_free;
   logic                                   req_take;
   logic                                   scan_done;
   load_type                               load;
   logic [DICT_WORDS:0]                    hit_chain;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || ((req.kind == KIND_BEGIN) && !out_free);
   assign req_take  = req_valid && !req_stall;
   assign scan_done = (state_ff == ST_SCAN) && (cnt_ff == CNT_W'(DICT_WORDS));

   assign load.en     = req_take && (req.kind == KIND_LOAD);
   assign load.slot   = req.word_slot;
   assign load.bytes  = req.word_bytes;
   assign load.length = req.word_length;

   assign hit_chain[0] = 1'b0;

   for (genvar g = 0; g < DICT_WORDS; g++) begin : g_cell
      wbs_cell #(
         .MAX_WORD_LEN (MAX_WORD_LEN),
         .SLOT_INDEX   (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .load       (load),
         .byte_hist  (byte_hist_ff),
         .split_hist (split_hist_ff),
         .hit_in     (hit_chain[g]),
         .hit_out    (hit_chain[g+1])
      );
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      byte_hist_in  = byte_hist_ff;
      split_hist_in = split_hist_ff;
      last_in       = last_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req.kind)
                  KIND_TEXT: begin
                     for (int k = MAX_WORD_LEN - 1; k > 0; k--) begin
                        byte_hist_in[k] = byte_hist_ff[k-1];
                     end
                     byte_hist_in[0] = req.text_char;
                     last_in         = req.last_char;
                     cnt_in          = '0;
                     state_in        = ST_SCAN;
                  end
                  KIND_BEGIN: begin
                     byte_hist_in         = '0;
                     split_hist_in        = '0;
                     split_hist_in[0]     = 1'b1;
                     rsp_in.prefix_breakable = 1'b1;
                     rsp_in.is_end        = 1'b0;
                     rsp_valid_in         = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!scan_done) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else if (out_free) begin
               for (int k = MAX_WORD_LEN - 1; k > 0; k--) begin
                  split_hist_in[k] = split_hist_ff[k-1];
               end
               split_hist_in[0]        = hit_chain[DICT_WORDS];
               rsp_in.prefix_breakable = hit_chain[DICT_WORDS];
               rsp_in.is_end           = last_ff;
               rsp_valid_in            = 1'b1;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      last_ff <= last_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         byte_hist_ff  <= '0;
         split_hist_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         byte_hist_ff  <= byte_hist_in;
         split_hist_ff <= split_hist_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- src/wbs_checker.sv -----
// ----------------------------------------------------------------------------
// Word break segmenter checker
// Port level checks on the handshake and on the response timing of the
// segmenter, bound to the top level.
// ----------------------------------------------------------------------------
module wbs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input wbs_pkg::req_type req,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input wbs_pkg::rsp_type rsp
);
   import wbs_pkg::*;

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("Stalled response word changed or was dropped.");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid right after reset.");

   a_begin_rsp : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req.kind == KIND_BEGIN)
      |=> rsp_valid && rsp.prefix_breakable && !rsp.is_end)
      else $error("Begin word did not produce a splittable empty prefix.");

   a_text_busy : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req.kind == KIND_TEXT) |=> req_stall)
      else $error("Request taken while a text byte is being matched.");

endmodule

bind word_break_segmenter_unit wbs_checker u_wbs_checker (.*);

// ----- test/word_break_segmenter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Word break segmenter testbench
// Loads small dictionaries and streams texts that are mostly built from the
// loaded words, with random breaks, freed slots, oversized lengths, unused
// kinds and random bytes mixed in. Every accepted word is run through a local
// model of the segmenter, and each response is checked against the oldest
// prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module word_break_segmenter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wbs_pkg::*;

   localparam int DICT_N      = 16;
   localparam int MAX_LEN     = 8;
   localparam int TARGET      = 600;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN       = 40;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic [CHAR_W-1:0] CHAR_A      = 8'h61;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   word_break_segmenter_unit #(
      .DICT_WORDS  (DICT_N),
      .MAX_WORD_LEN(MAX_LEN)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req      (req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp      (rsp)
   );

   req_type pending_words[$];
   rsp_type splits_due[$];

   logic [WORD_W-1:0] dict_word [DICT_N];
   logic [LEN_W-1:0]  dict_len  [DICT_N];
   logic              slot_on   [DICT_N];
   logic [CHAR_W-1:0] byte_hist [MAX_LEN];
   logic [MAX_LEN-1:0] split_hist;

   logic [WORD_W-1:0] gen_word [DICT_N];
   int                gen_len  [DICT_N];

   int      word_count  = 0;
   int      cycle_count = 0;
   int      error_count = 0;
   int      gap_left    = 0;
   int      stall_left  = 0;
   logic    calm;
   rsp_type due;

   assign calm = (cycle_count % 4000) < 700;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      for (int s = 0; s < DICT_N; s++) begin
         dict_word[s] = '0;
         dict_len[s]  = '0;
         slot_on[s]   = 1'b0;
         gen_word[s]  = '0;
         gen_len[s]   = 0;
      end
      for (int k = 0; k < MAX_LEN; k++) begin
         byte_hist[k] = '0;
      end
      split_hist = '0;
   end

   function automatic void add_pending(req_type w);
      pending_words.insert(pending_words.size(), w);
   endfunction

   function automatic void add_due(rsp_type r);
      splits_due.insert(splits_due.size(), r);
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void segment_step(req_type w);
      logic    hit;
      logic    match;
      int      l;
      rsp_type r;
      hit = 1'b0;
      case (w.kind)
         KIND_LOAD: begin
            if (w.word_length == 0 || w.word_length > MAX_LEN) begin
               dict_word[w.word_slot] = '0;
               dict_len[w.word_slot]  = '0;
               slot_on[w.word_slot]   = 1'b0;
            end else begin
               dict_word[w.word_slot] = w.word_bytes;
               dict_len[w.word_slot]  = w.word_length;
               slot_on[w.word_slot]   = 1'b1;
            end
         end
         KIND_BEGIN: begin
            for (int k = 0; k < MAX_LEN; k++) begin
               byte_hist[k] = '0;
            end
            split_hist = MAX_LEN'(1);
            r.prefix_breakable = 1'b1;
            r.is_end           = 1'b0;
            add_due(r);
         end
         KIND_TEXT: begin
            for (int k = MAX_LEN - 1; k > 0; k--) begin
               byte_hist[k] = byte_hist[k-1];
            end
            byte_hist[0] = w.text_char;
            for (int s = 0; s < DICT_N; s++) begin
               l = int'(dict_len[s]);
               if (slot_on[s] && l >= 1 && l <= MAX_LEN && split_hist[l-1]) begin
                  match = 1'b1;
                  for (int m = 0; m < l; m++) begin
                     if (byte_hist[l-1-m] != dict_word[s][8*m +: 8]) match = 1'b0;
                  end
                  if (match) hit = 1'b1;
               end
            end
            split_hist = {split_hist[MAX_LEN-2:0], hit};
            r.prefix_breakable = hit;
            r.is_end           = w.last_char;
            add_due(r);
         end
         default: ;
      endcase
   endfunction

   function automatic req_type junk_item(logic [KIND_W-1:0] k);
      req_type w;
      w.kind        = k;
      w.word_slot   = SLOT_W'($urandom);
      w.word_bytes  = {$urandom, $urandom};
      w.word_length = LEN_W'($urandom);
      w.text_char   = CHAR_W'($urandom);
      w.last_char   = 1'($urandom);
      return w;
   endfunction

   function automatic logic [WORD_W-1:0] alpha_word(int len);
      logic [WORD_W-1:0] b;
      b = {$urandom, $urandom};
      for (int m = 0; m < len && m < MAX_LEN; m++) begin
         b[8*m +: 8] = CHAR_A + CHAR_W'($urandom_range(0, 2));
      end
      return b;
   endfunction

   task automatic queue_load(int slot, int len, logic [WORD_W-1:0] b);
      req_type w;
      w = junk_item(KIND_LOAD);
      w.word_slot   = SLOT_W'(slot);
      w.word_length = LEN_W'(len);
      w.word_bytes  = b;
      add_pending(w);
      gen_word[slot] = b;
      gen_len[slot]  = (len == 0 || len > MAX_LEN) ? 0 : len;
      word_count++;
   endtask

   task automatic queue_text(logic [CHAR_W-1:0] ch, logic last);
      req_type w;
      w = junk_item(KIND_TEXT);
      w.text_char = ch;
      w.last_char = last;
      add_pending(w);
      word_count++;
   endtask

   task automatic queue_begin();
      add_pending(junk_item(KIND_BEGIN));
      word_count++;
   endtask

   task automatic queue_dict_update();
      int n;
      int r;
      int len;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 19);
         if (r < 13) len = $urandom_range(1, 3);
         else if (r < 16) len = $urandom_range(4, 8);
         else if (r < 18) len = 0;
         else len = $urandom_range(9, 15);
         if ($urandom_range(0, 9) == 0) begin
            queue_load($urandom_range(0, DICT_N - 1), len, {$urandom, $urandom});
         end else begin
            queue_load($urandom_range(0, DICT_N - 1), len, alpha_word(len));
         end
      end
   endtask

   task automatic queue_sentence();
      int   n_words;
      int   s;
      logic last_word;
      if ($urandom_range(0, 9) != 0) queue_begin();
      n_words = $urandom_range(1, 6);
      for (int i = 0; i < n_words; i++) begin
         last_word = (i == n_words - 1);
         s = -1;
         for (int t = 0; t < 16 && s < 0; t++) begin
            s = $urandom_range(0, DICT_N - 1);
            if (gen_len[s] == 0) s = -1;
         end
         if (s < 0 || $urandom_range(0, 7) == 0) begin
            queue_text(CHAR_A + CHAR_W'($urandom_range(0, 2)), last_word);
         end else begin
            for (int m = 0; m < gen_len[s]; m++) begin
               queue_text(gen_word[s][8*m +: 8], last_word && m == gen_len[s] - 1);
            end
         end
      end
   endtask

   initial begin
      int r;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      queue_text(CHAR_A, 1'b1);
      queue_load(0, 2, 64'hFFFF_FFFF_FFFF_6261);
      queue_load(15, 8, '1);
      queue_load(1, 1, 64'h61);
      queue_load(2, 1, 64'h62);
      queue_load(2, 15, 64'h62);
      queue_load(3, 0, '1);
      add_pending(junk_item(KIND_UNUSED));
      queue_begin();
      queue_begin();
      queue_text(8'h61, 1'b0);
      queue_text(8'h62, 1'b0);
      queue_text(8'h62, 1'b0);
      queue_text(8'h61, 1'b1);
      queue_begin();
      for (int i = 0; i < MAX_LEN; i++) begin
         queue_text(8'hFF, i == MAX_LEN - 1);
      end
      queue_text(8'h00, 1'b0);
      queue_text(8'h61, 1'b1);

      repeat (3) queue_dict_update();
      while (word_count < TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            queue_dict_update();
         end else if (r < 19) begin
            add_pending(junk_item(KIND_UNUSED));
         end else if (r < 22) begin
            queue_text(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else begin
            queue_sentence();
         end
      end

      while (pending_words.size() != 0 || req_valid || splits_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall) segment_step(req);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left  <= gap_left - 1;
            end else if (pending_words.size() != 0) begin
               req       <= pending_words.pop_front();
               req_valid <= 1'b1;
               gap_left  <= calm ? 0 : gap_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (splits_due.size() == 0) begin
               $error("unexpected response: prefix_breakable=%0b is_end=%0b",
                      rsp.prefix_breakable, rsp.is_end);
               error_count++;
            end else begin
               due = splits_due.pop_front();
               if (rsp.prefix_breakable !== due.prefix_breakable) begin
                  $error("prefix_breakable: expected %0b, got %0b",
                         due.prefix_breakable, rsp.prefix_breakable);
                  error_count++;
               end
               if (rsp.is_end !== due.is_end) begin
                  $error("is_end: expected %0b, got %0b", due.is_end, rsp.is_end);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (!calm && $urandom_range(0, 9) < 3) begin
            rsp_stall  <= 1'b1;
            stall_left <= gap_len();
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
